/* sv/nps_pkg.sv */
// Package: widths, codes and defaults shared by the interrupt scheduler files.
`default_nettype none
package nps_pkg;

    localparam int LEVELS_DEF        = 5;
    localparam int PENDING_WIDTH_DEF = 8;
    localparam int IDLE_WIDTH_DEF    = 16;

    localparam int OPCODE_W = 1;
    localparam int LEVEL_W  = 3;
    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 16;
    localparam int STEPS_W  = 4;
    localparam int PROG_W   = 4;

    localparam logic [STEPS_W-1:0] STEPS_RESET = 4'd5;
    localparam logic [STEPS_W-1:0] STEPS_MAX   = 4'd14;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic [0:0] {
        REG_STEPS = 1'b0,
        REG_NONE  = 1'b1
    } t_reg_index;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK = 1'b0,
        OP_REQ  = 1'b1
    } t_opcode;

    typedef enum logic [KIND_W-1:0] {
        KIND_IDLE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STEP  = 3'd2,
        KIND_END   = 3'd3,
        KIND_REQ   = 3'd4
    } t_kind;

endpackage : nps_pkg
`default_nettype wire

/* sv/nps_if.sv */
// Interfaces: request/tick item channel and result channel.
`default_nettype none
interface nps_item_if import nps_pkg::*;;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [LEVEL_W-1:0]  level;

    modport source (output valid, output opcode, output level, input ready);
    modport sink   (input valid, input opcode, input level, output ready);
endinterface : nps_item_if

interface nps_result_if import nps_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [LEVEL_W-1:0] served_level;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output kind, output served_level, output value,
                    input ready);
    modport sink   (input valid, input kind, input served_level, input value,
                    output ready);
endinterface : nps_result_if
`default_nettype wire

/* sv/nested_priority_interrupt_scheduler.sv */
// Top level of the nested priority interrupt scheduler.
//
// Items arrive on i_item (valid/ready): opcode 1 notes an interrupt request at
// the given level, opcode 0 is a timer tick that serves the highest level with
// pending requests or a handler in progress, or advances the idle counter.
// Each item gives exactly one result beat on o_res: kind, served level, value.
// An accepted input beat passes the input register and then the result
// register before its result beat is valid; one item is taken every cycle
// while the receiver does not stall, set by the combinational select and update
// between the input register and the result register.
// When the receiver stalls, the result register holds and one further item
// waits in the input register; ready then drops until the result is taken.
// The APB port holds steps_per_service at byte address 0 (reset value 5);
// write it only while no item is in flight.
// Synchronous active-low reset clears pending counts, handler progress, the
// idle counter and both valid flags; the block takes items on the next cycle.
`default_nettype none
module nested_priority_interrupt_scheduler import nps_pkg::*; #(
    parameter int LEVELS        = LEVELS_DEF,
    parameter int PENDING_WIDTH = PENDING_WIDTH_DEF,
    parameter int IDLE_WIDTH    = IDLE_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    nps_item_if.sink                   i_item,
    nps_result_if.source               o_res
);

    logic [STEPS_W-1:0] steps;

    nps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_steps (steps)
    );

    nps_core #(
        .LEVELS        (LEVELS),
        .PENDING_WIDTH (PENDING_WIDTH),
        .IDLE_WIDTH    (IDLE_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_steps (steps),
        .i_item  (i_item),
        .o_res   (o_res)
    );

endmodule : nested_priority_interrupt_scheduler
`default_nettype wire

/* sv/nps_cfg.sv */
// APB register block: holds the steps-per-service register.
`default_nettype none
module nps_cfg import nps_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [STEPS_W-1:0]    o_steps
);

    logic [STEPS_W-1:0] r_steps;
    t_reg_index         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_index'(paddr[2]);
    assign o_steps = r_steps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEPS_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel == REG_STEPS) begin
            r_steps <= pwdata[STEPS_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_STEPS: begin
                prdata = APB_DATA_W'(r_steps);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule : nps_cfg
`default_nettype wire

/* sv/nps_core.sv */
// Scheduler core: input register, priority select and state update, result register.
`default_nettype none
module nps_core import nps_pkg::*; #(
    parameter int LEVELS        = LEVELS_DEF,
    parameter int PENDING_WIDTH = PENDING_WIDTH_DEF,
    parameter int IDLE_WIDTH    = IDLE_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [STEPS_W-1:0] i_steps,
    nps_item_if.sink                i_item,
    nps_result_if.source            o_res
);

    localparam int SEL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic                     r_in_valid;
    logic [OPCODE_W-1:0]      r_opcode;
    logic [LEVEL_W-1:0]       r_level;

    logic [PENDING_WIDTH-1:0] r_pending [LEVELS];
    logic [PENDING_WIDTH-1:0] n_pending [LEVELS];
    logic [PROG_W-1:0]        r_prog    [LEVELS];
    logic [PROG_W-1:0]        n_prog    [LEVELS];
    logic [IDLE_WIDTH-1:0]    r_idle;
    logic [IDLE_WIDTH-1:0]    n_idle;

    logic                     r_out_valid;
    t_kind                    r_kind;
    t_kind                    n_kind;
    logic [LEVEL_W-1:0]       r_served;
    logic [LEVEL_W-1:0]       n_served;
    logic [VALUE_W-1:0]       r_value;
    logic [VALUE_W-1:0]       n_value;

    logic                     advance;
    logic                     fire;
    logic                     sel_found;
    logic [SEL_W-1:0]         sel_idx;
    logic [PROG_W-1:0]        sel_prog;
    logic [STEPS_W-1:0]       steps_eff;
    logic                     ending;
    logic [31:0]              idle_ext;

    assign advance      = !r_out_valid || o_res.ready;
    assign fire         = r_in_valid && advance;
    assign i_item.ready = !r_in_valid || advance;

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_kind;
    assign o_res.served_level = r_served;
    assign o_res.value        = r_value;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_opcode <= i_item.opcode;
            r_level  <= i_item.level;
        end
    end

    // highest active level wins
    always_comb begin
        sel_found = 1'b0;
        sel_idx   = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_pending[i] != '0 || r_prog[i] != '0) begin
                sel_found = 1'b1;
                sel_idx   = SEL_W'(i);
            end
        end
    end

    assign sel_prog  = r_prog[sel_idx];
    assign steps_eff = (i_steps > STEPS_MAX) ? STEPS_MAX : i_steps;
    assign ending    = {1'b0, sel_prog} >= ({1'b0, steps_eff} + 5'd1);
    assign idle_ext  = 32'(n_idle);

    always_comb begin
        n_pending = r_pending;
        n_prog    = r_prog;
        n_idle    = r_idle;
        n_kind    = KIND_IDLE;
        n_served  = '0;
        n_value   = '0;
        if (r_opcode == OP_REQ) begin
            for (int i = 0; i < LEVELS; i++) begin
                if ({2'b00, r_level} == 5'(i) && r_pending[i] != '1) begin
                    n_pending[i] = r_pending[i] + 1'b1;
                end
            end
            n_kind   = KIND_REQ;
            n_served = r_level;
        end else if (!sel_found) begin
            n_idle  = r_idle + 1'b1;
            n_kind  = KIND_IDLE;
            n_value = idle_ext[VALUE_W-1:0];
        end else begin
            n_served = LEVEL_W'(sel_idx);
            if (sel_prog == '0) begin
                n_pending[sel_idx] = r_pending[sel_idx] - 1'b1;
                n_prog[sel_idx]    = PROG_W'(1);
                n_kind             = KIND_START;
            end else if (ending) begin
                n_prog[sel_idx] = '0;
                n_kind          = KIND_END;
            end else begin
                n_prog[sel_idx] = sel_prog + 1'b1;
                n_kind          = KIND_STEP;
                n_value         = VALUE_W'(sel_prog);
            end
        end
    end

    // scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_pending[i] <= '0;
                r_prog[i]    <= '0;
            end
            r_idle <= '0;
        end else if (fire) begin
            r_pending <= n_pending;
            r_prog    <= n_prog;
            r_idle    <= n_idle;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_kind   <= n_kind;
            r_served <= n_served;
            r_value  <= n_value;
        end
    end

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_level) && $stable(r_opcode))
        else $error("input beat lost while result stalled");

    a_step_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == KIND_STEP |-> r_value != '0 && r_value <= 16'd15)
        else $error("step beat carries bad step number");

    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_kind == KIND_START || r_kind == KIND_END || r_kind == KIND_REQ)
        |-> r_value == '0)
        else $error("non-step beat carries a value");

endmodule : nps_core
`default_nettype wire
